/* rtl/core/nfcp_pkg.sv */
// ----------------------------------------------------------------------------
// nfcp_pkg
// Shared types and codes for the NFC response frame parser.
// ----------------------------------------------------------------------------
package nfcp_pkg;

  // Input kinds carried on the slave-side tuser
  localparam logic CMD_BEGIN = 1'b0;
  localparam logic CMD_BYTE  = 1'b1;

  // Parser phase codes
  localparam logic [3:0] PH_IDLE = 4'd0;
  localparam logic [3:0] PH_PRE  = 4'd1;
  localparam logic [3:0] PH_SC1  = 4'd2;
  localparam logic [3:0] PH_SC2  = 4'd3;
  localparam logic [3:0] PH_LEN  = 4'd4;
  localparam logic [3:0] PH_LCS  = 4'd5;
  localparam logic [3:0] PH_TFI  = 4'd6;
  localparam logic [3:0] PH_CODE = 4'd7;
  localparam logic [3:0] PH_DATA = 4'd8;
  localparam logic [3:0] PH_DCS  = 4'd9;
  localparam logic [3:0] PH_POST = 4'd10;
  localparam logic [3:0] PH_DROP = 4'd11;

  // Frame status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FRAME   = 3'd1;
  localparam logic [2:0] ST_NODATA  = 3'd2;
  localparam logic [2:0] ST_LCS     = 3'd3;
  localparam logic [2:0] ST_NOSPACE = 3'd4;
  localparam logic [2:0] ST_DCS     = 3'd5;

  // Fixed frame bytes
  localparam logic [7:0] PREAMBLE    = 8'h00;
  localparam logic [7:0] START_CODE0 = 8'h00;
  localparam logic [7:0] START_CODE1 = 8'hFF;

  // Reset value of the expected frame identifier
  localparam logic [7:0] FRAME_ID_RESET = 8'hD5;

  // Stream widths
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 24;

  // One result beat
  typedef struct packed {
    logic       is_status;
    logic [7:0] data_byte;
    logic [2:0] status;
    logic [7:0] byte_count;
    logic       last;
  } res_t;

endpackage

/* rtl/core/nfcp_core.sv */
// ----------------------------------------------------------------------------
// nfcp_core
// Frame state registers and the single-pass check of one input beat.
// ----------------------------------------------------------------------------
module nfcp_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata,
  input  logic                in_accept,
  input  logic                cmd,
  input  logic [7:0]          command_code,
  input  logic [7:0]          capacity,
  input  logic [7:0]          rx_byte,
  output logic                res_valid,
  output nfcp_pkg::res_t      res
);

  logic [3:0] phase, phase_next;
  logic [7:0] remaining, remaining_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] expected_code, expected_code_next;
  logic [7:0] buffer_size, buffer_size_next;
  logic [7:0] payload_len, payload_len_next;
  logic [2:0] pending_status, pending_status_next;
  logic [7:0] frame_id;

  logic [7:0] plen;
  logic [7:0] rem_dec;
  logic [7:0] sum_add;
  logic       emit;
  logic [2:0] emit_st;

  assign plen    = remaining - 8'd2;
  assign rem_dec = remaining - 8'd1;
  assign sum_add = running_sum + rx_byte;

  // Hold the frame identifier register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_id <= nfcp_pkg::FRAME_ID_RESET;
    end else if (cfg_we) begin
      frame_id <= cfg_wdata;
    end
  end

  // Work out the next state and the result of one beat
  always_comb begin
    phase_next          = phase;
    remaining_next      = remaining;
    running_sum_next    = running_sum;
    expected_code_next  = expected_code;
    buffer_size_next    = buffer_size;
    payload_len_next    = payload_len;
    pending_status_next = pending_status;
    emit                = 1'b0;
    emit_st             = nfcp_pkg::ST_OK;
    res_valid           = 1'b0;
    res                 = '0;

    if (cmd == nfcp_pkg::CMD_BEGIN) begin
      expected_code_next  = command_code;
      buffer_size_next    = capacity;
      remaining_next      = 8'd0;
      running_sum_next    = 8'd0;
      payload_len_next    = 8'd0;
      pending_status_next = nfcp_pkg::ST_OK;
      phase_next          = nfcp_pkg::PH_PRE;
    end else begin
      case (phase)
        nfcp_pkg::PH_PRE: begin
          if (rx_byte != nfcp_pkg::PREAMBLE) begin
            emit = 1'b1; emit_st = nfcp_pkg::ST_FRAME;
          end else phase_next = nfcp_pkg::PH_SC1;
        end
        nfcp_pkg::PH_SC1: begin
          if (rx_byte != nfcp_pkg::START_CODE0) begin
            emit = 1'b1; emit_st = nfcp_pkg::ST_FRAME;
          end else phase_next = nfcp_pkg::PH_SC2;
        end
        nfcp_pkg::PH_SC2: begin
          if (rx_byte != nfcp_pkg::START_CODE1) begin
            emit = 1'b1; emit_st = nfcp_pkg::ST_FRAME;
          end else phase_next = nfcp_pkg::PH_LEN;
        end
        nfcp_pkg::PH_LEN: begin
          if (rx_byte == 8'd0) begin
            emit = 1'b1; emit_st = nfcp_pkg::ST_NODATA;
          end else begin
            remaining_next = rx_byte;
            phase_next     = nfcp_pkg::PH_LCS;
          end
        end
        nfcp_pkg::PH_LCS: begin
          if (8'(remaining + rx_byte) != 8'd0) begin
            emit = 1'b1; emit_st = nfcp_pkg::ST_LCS;
          end else phase_next = nfcp_pkg::PH_TFI;
        end
        nfcp_pkg::PH_TFI: begin
          if (rx_byte != frame_id) begin
            emit = 1'b1; emit_st = nfcp_pkg::ST_FRAME;
          end else begin
            running_sum_next = rx_byte;
            phase_next       = nfcp_pkg::PH_CODE;
          end
        end
        nfcp_pkg::PH_CODE: begin
          if ((rx_byte != 8'(expected_code + 8'd1)) || (remaining < 8'd2)) begin
            emit = 1'b1; emit_st = nfcp_pkg::ST_FRAME;
          end else begin
            running_sum_next = sum_add;
            payload_len_next = plen;
            if (plen > buffer_size) begin
              // Drop payload, DCS and postamble
              pending_status_next = nfcp_pkg::ST_NOSPACE;
              phase_next          = nfcp_pkg::PH_DROP;
            end else begin
              remaining_next = plen;
              phase_next     = (plen == 8'd0) ? nfcp_pkg::PH_DCS : nfcp_pkg::PH_DATA;
            end
          end
        end
        nfcp_pkg::PH_DATA: begin
          running_sum_next = sum_add;
          remaining_next   = rem_dec;
          if (rem_dec == 8'd0) phase_next = nfcp_pkg::PH_DCS;
          res_valid     = 1'b1;
          res.data_byte = rx_byte;
        end
        nfcp_pkg::PH_DCS: begin
          if (sum_add != 8'd0) begin
            emit = 1'b1; emit_st = nfcp_pkg::ST_DCS;
          end else phase_next = nfcp_pkg::PH_POST;
        end
        nfcp_pkg::PH_POST: begin
          emit = 1'b1; emit_st = nfcp_pkg::ST_OK;
        end
        nfcp_pkg::PH_DROP: begin
          remaining_next = rem_dec;
          if (rem_dec == 8'd0) begin
            emit = 1'b1; emit_st = pending_status;
          end
        end
        default: begin
          // Bytes while idle are ignored
          phase_next = nfcp_pkg::PH_IDLE;
        end
      endcase

      // Close the frame with its status beat
      if (emit) begin
        res_valid      = 1'b1;
        res.is_status  = 1'b1;
        res.status     = emit_st;
        res.byte_count = (emit_st == nfcp_pkg::ST_OK) ? payload_len : 8'd0;
        res.last       = 1'b1;
        phase_next     = nfcp_pkg::PH_IDLE;
      end
    end
  end

  // Advance the frame state on an accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= nfcp_pkg::PH_IDLE;
      remaining      <= 8'd0;
      running_sum    <= 8'd0;
      expected_code  <= 8'd0;
      buffer_size    <= 8'd0;
      payload_len    <= 8'd0;
      pending_status <= nfcp_pkg::ST_OK;
    end else if (in_accept) begin
      phase          <= phase_next;
      remaining      <= remaining_next;
      running_sum    <= running_sum_next;
      expected_code  <= expected_code_next;
      buffer_size    <= buffer_size_next;
      payload_len    <= payload_len_next;
      pending_status <= pending_status_next;
    end
  end

  // A status beat always returns the parser to idle
  a_status_idle: assert property (@(posedge clk) disable iff (rst)
    (in_accept && res_valid && res.is_status) |=> (phase == nfcp_pkg::PH_IDLE))
    else $error("parser not idle after status beat");

  // Payload beats only come out of the data phase
  a_data_phase: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.is_status) |-> (phase == nfcp_pkg::PH_DATA && remaining != 8'd0))
    else $error("payload beat outside data phase");

  // Only a status beat closes a frame
  a_last_on_status: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.last == res.is_status))
    else $error("last flag does not match status beat");

endmodule

/* rtl/core/nfcp_out_buf.sv */
// ----------------------------------------------------------------------------
// nfcp_out_buf
// Two-entry result buffer that parts the parser from the master side.
// ----------------------------------------------------------------------------
module nfcp_out_buf (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  nfcp_pkg::res_t push_data,
  output logic           has_room,
  output logic           out_valid,
  input  logic           out_ready,
  output nfcp_pkg::res_t out_data
);

  logic [1:0]     count, count_next;
  nfcp_pkg::res_t slot0;
  nfcp_pkg::res_t slot1;
  logic           pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign out_data  = slot0;
  assign has_room  = (count != 2'd2);

  // Track fill level
  always_comb begin
    count_next = count;
    if (push && !pop) count_next = count + 2'd1;
    else if (!push && pop) count_next = count - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  // Shift or load the slots
  always_ff @(posedge clk) begin
    if (pop) begin
      if (count == 2'd2) slot0 <= slot1;
      else if (push) slot0 <= push_data;
    end else if (push) begin
      if (count == 2'd0) slot0 <= push_data;
      else slot1 <= push_data;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result buffer count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && count == 2'd2))
    else $error("result buffer overflow");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (count == $past(count) - 2'd1))
    else $error("result buffer count did not drop on pop");

endmodule

/* rtl/core/nfc_response_frame_parser.sv */
// ----------------------------------------------------------------------------
// nfc_response_frame_parser
// Checks a controller-to-host information frame one byte per beat.
// ----------------------------------------------------------------------------
// Each input beat is checked combinationally: the frame check is a single pass of
// byte-wide logic from the frame state registers into a two-entry result
// buffer, so a new beat is accepted in every cycle while the master side
// keeps up, and s_tready drops only when both buffer entries are full.
// A begin beat (s_tuser 0) arms the block with the command code and the
// payload capacity; byte beats (s_tuser 1) carry frame bytes. Payload bytes
// come out with m_tuser 0; each frame closes with one status beat with
// m_tuser 1 and m_tlast 1. The frame identifier is written over cfg_we.
module nfc_response_frame_parser (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [7:0]                         cfg_wdata,  // response_frame_id
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [7:0] command_code, [15:8] capacity, [23:16] rx_byte
  input  logic [nfcp_pkg::IN_DATA_W-1:0]     s_tdata,
  input  logic                               s_tuser,    // [0] cmd
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [7:0] data_byte, [10:8] status, [18:11] byte_count, [23:19] zero
  output logic [nfcp_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic                               m_tuser,    // [0] is_status
  output logic                               m_tlast
);

  logic           in_accept;
  logic           res_valid;
  nfcp_pkg::res_t res;
  nfcp_pkg::res_t out_res;
  logic           has_room;

  assign s_tready  = has_room;
  assign in_accept = s_tvalid && s_tready;

  // Check the accepted beat
  nfcp_core u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_accept    (in_accept),
    .cmd          (s_tuser),
    .command_code (s_tdata[7:0]),
    .capacity     (s_tdata[15:8]),
    .rx_byte      (s_tdata[23:16]),
    .res_valid    (res_valid),
    .res          (res)
  );

  // Hold results until the master side takes them
  nfcp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (in_accept && res_valid),
    .push_data (res),
    .has_room  (has_room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  // Pack the result beat
  assign m_tdata = {5'd0, out_res.byte_count, out_res.status, out_res.data_byte};
  assign m_tuser = out_res.is_status;
  assign m_tlast = out_res.last;

endmodule

/* sim/frame_parser_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_parser_checker
// Watches the input, config and result channels of the response frame
// parser, keeps its own model of the frame walk and compares every result
// beat, field by field, with the oldest beat that the model has queued.
// ----------------------------------------------------------------------------
module frame_parser_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [7:0]                      cfg_wdata,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [nfcp_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                            s_tuser,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [nfcp_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                            m_tuser,
  input  logic                            m_tlast,
  output int                              fail_count,
  output int                              pending_results,
  output int                              beats_in,
  output int                              payload_seen,
  output int                              status_seen,
  output int                              ok_seen,
  output int                              nospace_seen
);

  // Model copy of the parser state
  logic [7:0] frame_id;
  logic [3:0] stage;
  logic [7:0] left;
  logic [7:0] csum;
  logic [7:0] want_code;
  logic [7:0] room;
  logic [7:0] plen;
  logic [2:0] held_status;

  // Result beats owed by the parser, oldest first
  nfcp_pkg::res_t frame_results_due[$];

  initial begin
    fail_count = 0;
    pending_results = 0;
    beats_in = 0;
    payload_seen = 0;
    status_seen = 0;
    ok_seen = 0;
    nospace_seen = 0;
  end

  // Queue the closing status of a frame and return to idle
  task automatic close_frame(input logic [2:0] st);
    nfcp_pkg::res_t r;
    r.is_status  = 1'b1;
    r.data_byte  = 8'h00;
    r.status     = st;
    r.byte_count = (st == nfcp_pkg::ST_OK) ? plen : 8'h00;
    r.last       = 1'b1;
    frame_results_due.push_back(r);
    stage = nfcp_pkg::PH_IDLE;
  endtask

  // Advance the model by one accepted input beat
  task automatic track_rx_beat(input logic cmd, input logic [7:0] code,
                               input logic [7:0] cap, input logic [7:0] b);
    nfcp_pkg::res_t r;
    if (cmd == nfcp_pkg::CMD_BEGIN) begin
      want_code   = code;
      room        = cap;
      left        = 8'h00;
      csum        = 8'h00;
      plen        = 8'h00;
      held_status = nfcp_pkg::ST_OK;
      stage       = nfcp_pkg::PH_PRE;
    end else begin
      case (stage)
        nfcp_pkg::PH_PRE: begin
          if (b != nfcp_pkg::PREAMBLE) close_frame(nfcp_pkg::ST_FRAME);
          else stage = nfcp_pkg::PH_SC1;
        end
        nfcp_pkg::PH_SC1: begin
          if (b != nfcp_pkg::START_CODE0) close_frame(nfcp_pkg::ST_FRAME);
          else stage = nfcp_pkg::PH_SC2;
        end
        nfcp_pkg::PH_SC2: begin
          if (b != nfcp_pkg::START_CODE1) close_frame(nfcp_pkg::ST_FRAME);
          else stage = nfcp_pkg::PH_LEN;
        end
        nfcp_pkg::PH_LEN: begin
          if (b == 8'h00) begin
            close_frame(nfcp_pkg::ST_NODATA);
          end else begin
            left  = b;
            stage = nfcp_pkg::PH_LCS;
          end
        end
        nfcp_pkg::PH_LCS: begin
          if (8'(left + b) != 8'h00) close_frame(nfcp_pkg::ST_LCS);
          else stage = nfcp_pkg::PH_TFI;
        end
        nfcp_pkg::PH_TFI: begin
          if (b != frame_id) begin
            close_frame(nfcp_pkg::ST_FRAME);
          end else begin
            csum  = b;
            stage = nfcp_pkg::PH_CODE;
          end
        end
        nfcp_pkg::PH_CODE: begin
          if (b != 8'(want_code + 8'd1) || left < 8'd2) begin
            close_frame(nfcp_pkg::ST_FRAME);
          end else begin
            csum = 8'(csum + b);
            plen = 8'(left - 8'd2);
            // Payload too big for the receiver: swallow the rest of the frame
            if (plen > room) begin
              held_status = nfcp_pkg::ST_NOSPACE;
              left        = 8'(plen + 8'd2);
              stage       = nfcp_pkg::PH_DROP;
            end else begin
              left  = plen;
              stage = (plen == 8'h00) ? nfcp_pkg::PH_DCS : nfcp_pkg::PH_DATA;
            end
          end
        end
        nfcp_pkg::PH_DATA: begin
          csum = 8'(csum + b);
          left = 8'(left - 8'd1);
          if (left == 8'h00) stage = nfcp_pkg::PH_DCS;
          r.is_status  = 1'b0;
          r.data_byte  = b;
          r.status     = nfcp_pkg::ST_OK;
          r.byte_count = 8'h00;
          r.last       = 1'b0;
          frame_results_due.push_back(r);
        end
        nfcp_pkg::PH_DCS: begin
          if (8'(csum + b) != 8'h00) close_frame(nfcp_pkg::ST_DCS);
          else stage = nfcp_pkg::PH_POST;
        end
        nfcp_pkg::PH_POST: begin
          // Postamble value is consumed, never checked
          close_frame(nfcp_pkg::ST_OK);
        end
        nfcp_pkg::PH_DROP: begin
          left = 8'(left - 8'd1);
          if (left == 8'h00) close_frame(held_status);
        end
        default: begin
          // Bytes with no frame armed are ignored
          stage = nfcp_pkg::PH_IDLE;
        end
      endcase
    end
  endtask

  // Compare one field and report a mismatch
  task automatic check_field(input string what, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, what, want, got);
    end
  endtask

  // Sample all channels at each edge: model first, then the result compare
  always @(posedge clk) begin : watch
    nfcp_pkg::res_t got;
    nfcp_pkg::res_t want;
    if (rst) begin
      frame_id    = nfcp_pkg::FRAME_ID_RESET;
      stage       = nfcp_pkg::PH_IDLE;
      left        = 8'h00;
      csum        = 8'h00;
      want_code   = 8'h00;
      room        = 8'h00;
      plen        = 8'h00;
      held_status = nfcp_pkg::ST_OK;
      frame_results_due.delete();
    end else begin
      if (cfg_we) frame_id = cfg_wdata;
      if (s_tvalid && s_tready) begin
        beats_in++;
        track_rx_beat(s_tuser, s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]);
      end
      if (m_tvalid && m_tready) begin
        got = {m_tuser, m_tdata[7:0], m_tdata[10:8], m_tdata[18:11], m_tlast};
        if (frame_results_due.size() == 0) begin
          fail_count++;
          $display("%0t ns: result beat with none owed, expected nothing actual %h",
                   $time, got);
        end else begin
          want = frame_results_due.pop_front();
          check_field("is_status", {7'd0, want.is_status}, {7'd0, got.is_status});
          check_field("data_byte", want.data_byte, got.data_byte);
          check_field("status", {5'd0, want.status}, {5'd0, got.status});
          check_field("byte_count", want.byte_count, got.byte_count);
          check_field("last", {7'd0, want.last}, {7'd0, got.last});
        end
        check_field("tdata pad", 8'h00, {3'd0, m_tdata[23:19]});
        if (got.is_status) begin
          status_seen++;
          if (got.status == nfcp_pkg::ST_OK) ok_seen++;
          if (got.status == nfcp_pkg::ST_NOSPACE) nospace_seen++;
        end else begin
          payload_seen++;
        end
      end
    end
    pending_results <= frame_results_due.size();
  end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives framed controller responses into the parser: a few directed frames,
// then random frames, well formed for the most part with header, checksum,
// truncation and noise faults mixed in, over several frame-id settings.
// Both stream sides idle at random; the checker judges every result beat.
// ----------------------------------------------------------------------------
module testbench;

  localparam int LIMIT_NS      = 10_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 96;
  localparam int PHASE_BEATS   = 340;

  typedef enum int {
    FAULT_NONE,
    FAULT_PREAMBLE,
    FAULT_START0,
    FAULT_START1,
    FAULT_LCS,
    FAULT_TFI,
    FAULT_CODE,
    FAULT_DCS,
    FAULT_CUT,
    FAULT_NOISE
  } fault_t;

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            cfg_we    = 1'b0;
  logic [7:0]                      cfg_wdata = 8'h00;
  logic                            s_tvalid  = 1'b0;
  logic                            s_tready;
  logic [nfcp_pkg::IN_DATA_W-1:0]  s_tdata   = '0;
  logic                            s_tuser   = 1'b0;
  logic                            m_tvalid;
  logic                            m_tready  = 1'b0;
  logic [nfcp_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                            m_tuser;
  logic                            m_tlast;

  int fail_count;
  int pending_results;
  int beats_in;
  int payload_seen;
  int status_seen;
  int ok_seen;
  int nospace_seen;

  int         burst_left   = 0;
  int         items_sent   = 0;
  int         hold_asked   = 0;
  int         hold_given   = 0;
  int         hold_left    = 0;
  logic [15:0] rx_tick     = '0;
  logic [7:0] frame_id_now = nfcp_pkg::FRAME_ID_RESET;

  always #10 clk = ~clk;

  nfc_response_frame_parser uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  frame_parser_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser),
    .m_tlast         (m_tlast),
    .fail_count      (fail_count),
    .pending_results (pending_results),
    .beats_in        (beats_in),
    .payload_seen    (payload_seen),
    .status_seen     (status_seen),
    .ok_seen         (ok_seen),
    .nospace_seen    (nospace_seen)
  );

  // Receiver: long hold-offs on request, otherwise a stall pattern chosen by
  // rx_tick[8:7] (always ready, mostly ready, mostly stalled, 1 in 4)
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      rx_tick <= rx_tick + 16'd1;
      if (hold_left != 0) begin
        m_tready  <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (hold_given != hold_asked) begin
        m_tready   <= 1'b0;
        hold_left  <= HOLD_CYCLES;
        hold_given <= hold_given + 1;
      end else begin
        case (rx_tick[8:7])
          2'd0:    m_tready <= 1'b1;
          2'd1:    m_tready <= ($urandom_range(0, 3) != 0);
          2'd2:    m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= (rx_tick[1:0] == 2'd0);
        endcase
      end
    end
  end

  // Offer one beat, in bursts with random gaps between them
  task automatic put_beat(input logic cmd, input logic [7:0] code,
                          input logic [7:0] cap, input logic [7:0] rxb,
                          input bit tally);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 16);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {rxb, cap, code};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    if (tally) items_sent++;
  endtask

  // Arm the parser and feed one frame, optionally damaged
  task automatic send_frame(input logic [7:0] code, input logic [7:0] cap,
                            input logic [7:0] len, input fault_t flt);
    logic [7:0] fb[$];
    logic [7:0] sum;
    logic [7:0] pl;
    int stop;
    int spot;
    int keep;
    fb  = {nfcp_pkg::PREAMBLE, nfcp_pkg::START_CODE0, nfcp_pkg::START_CODE1, len,
           8'(-len), frame_id_now, 8'(code + 8'd1)};
    sum = 8'(frame_id_now + code + 8'd1);
    for (int i = 2; i < len; i++) begin
      pl = 8'($urandom_range(0, 255));
      fb.push_back(pl);
      sum = 8'(sum + pl);
    end
    fb.push_back(8'(-sum));
    fb.push_back(8'($urandom_range(0, 255)));

    // Frames with LEN zero or one end early
    stop = (len == 8'd0) ? 3 : (len == 8'd1) ? 6 : fb.size() - 1;
    case (flt)
      FAULT_PREAMBLE: spot = 0;
      FAULT_START0:   spot = 1;
      FAULT_START1:   spot = 2;
      FAULT_LCS:      spot = 4;
      FAULT_TFI:      spot = 5;
      FAULT_CODE:     spot = 6;
      FAULT_DCS:      spot = fb.size() - 2;
      default:        spot = -1;
    endcase
    if (spot >= 0 && spot <= stop) begin
      fb[spot] = fb[spot] ^ 8'($urandom_range(1, 255));
      if (flt != FAULT_DCS) stop = spot;
    end
    if (flt == FAULT_CUT) begin
      keep = $urandom_range(0, stop);
      stop = keep - 1;
    end
    if (flt == FAULT_NOISE) begin
      fb.delete();
      keep = $urandom_range(1, 12);
      for (int i = 0; i < keep; i++) fb.push_back(8'($urandom_range(0, 255)));
      stop = keep - 1;
    end

    put_beat(nfcp_pkg::CMD_BEGIN, code, cap, 8'($urandom_range(0, 255)), 1'b1);
    for (int i = 0; i <= stop; i++)
      put_beat(nfcp_pkg::CMD_BYTE, 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)), fb[i], 1'b1);
  endtask

  // Mostly short payloads, a few large ones; capacity at and around the size
  task automatic random_frame();
    logic [7:0] len;
    logic [7:0] cap;
    int n;
    int pick;
    fault_t flt;
    pick = $urandom_range(0, 99);
    if (pick < 3) len = 8'd0;
    else if (pick < 6) len = 8'd1;
    else if (pick < 90) len = 8'($urandom_range(2, 12));
    else if (pick < 97) len = 8'($urandom_range(13, 60));
    else len = 8'($urandom_range(200, 255));
    n = (len > 8'd1) ? int'(len) - 2 : 0;
    pick = $urandom_range(0, 99);
    if (pick < 8) cap = 8'd0;
    else if (pick < 16) cap = 8'd255;
    else if (pick < 30 && n > 0) cap = 8'($urandom_range(0, n - 1));
    else cap = 8'($urandom_range(n, 255));
    flt = ($urandom_range(0, 99) < 62) ? FAULT_NONE
                                       : fault_t'($urandom_range(1, int'(FAULT_NOISE)));
    send_frame(8'($urandom_range(0, 255)), cap, len, flt);
    // Now and then drop a few stray bytes on the line
    if ($urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(1, 3))
        put_beat(nfcp_pkg::CMD_BYTE, 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  // Stop offering and wait until the parser owes nothing
  task automatic settle();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_frame_id(input logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we       <= 1'b0;
    frame_id_now = v;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < 5; ph++) begin
      // Switch the frame identifier between phases, extremes included
      if (ph != 0) begin
        settle();
        case (ph)
          1:       write_frame_id(8'h00);
          2:       write_frame_id(8'hFF);
          3:       write_frame_id(8'($urandom_range(1, 254)));
          default: write_frame_id(nfcp_pkg::FRAME_ID_RESET);
        endcase
      end

      if (ph == 0) begin
        // Byte with no frame armed
        put_beat(nfcp_pkg::CMD_BYTE, 8'h00, 8'hFF, 8'hA5, 1'b1);
        // LEN zero, top command code
        send_frame(8'hFF, 8'hFF, 8'd0, FAULT_NONE);
        // LEN one, command code wraps to zero
        send_frame(8'hFF, 8'h00, 8'd1, FAULT_NONE);
        // One payload byte with no room: frame is swallowed
        send_frame(8'h00, 8'h00, 8'd3, FAULT_NONE);
      end

      // Hold the receiver off across a long payload to back up the input
      hold_asked <= hold_asked + 1;
      send_frame(8'($urandom_range(0, 255)), 8'hFF, 8'd50, FAULT_NONE);

      while (items_sent < (ph + 1) * PHASE_BEATS) random_frame();
      // Close the phase on a complete frame
      send_frame(8'($urandom_range(0, 255)), 8'hFF, 8'($urandom_range(2, 8)), FAULT_NONE);
    end

    settle();
    $display("Covered %0d input beats under 5 frame-id settings; %0d payload beats out.",
             beats_in, payload_seen);
    $display("Frame statuses: %0d total, %0d ok, %0d over capacity.",
             status_seen, ok_seen, nospace_seen);
    if (fail_count == 0 && pending_results == 0) begin
      $display("nfc_response_frame_parser verification clean");
    end else begin
      $display("nfc_response_frame_parser verification failed");
    end
    $finish;
  end

  // Hard stop in case the handshakes hang
  initial begin
    #LIMIT_NS;
    $display("Run hit the time limit with %0d results still owed.", pending_results);
    $display("nfc_response_frame_parser verification failed");
    $finish;
  end

endmodule
